[design/ai5p_pkg.sv]
// ----------------------------------------------------------------------------
// ai5p_pkg
// Shared types, constants and packing helpers for the 5-bit alphabet packer.
// ----------------------------------------------------------------------------
package ai5p_pkg;

  localparam int AlphabetSize = 31;
  localparam int CodeW        = 5;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 64;
  localparam int MaxResults   = 3;

  localparam logic [CodeW-1:0] TermCode = 5'd31;

  typedef enum logic [CfgIdxW-1:0] {
    CfgChars0  = 3'd0,
    CfgChars8  = 3'd1,
    CfgChars16 = 3'd2,
    CfgChars24 = 3'd3,
    CfgCount   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       byte_present;
    logic       symbol_unknown;
    logic       run_last;
    logic       stream_done;
  } res_t;

  // Up to three results of one item, in delivery order, with their count.
  typedef struct packed {
    res_t [MaxResults-1:0] res;
    logic [1:0]            num;
  } pack_out_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       emit;
    logic [6:0] bits;
    logic [2:0] cnt;
  } push_t;

  // Append one code MSB-first; split off a byte once eight bits are ready.
  function automatic push_t push_code(logic [6:0] bits, logic [2:0] cnt,
                                      logic [CodeW-1:0] code);
    logic [11:0] acc;
    logic [3:0]  tot;
    logic [2:0]  rem;
    logic [6:0]  mask;
    push_t       p;
    acc  = {bits, code};
    tot  = {1'b0, cnt} + 4'd5;
    rem  = tot[2:0];
    mask = 7'((8'd1 << rem) - 8'd1);
    p.emit     = tot[3];
    p.byte_out = tot[3] ? 8'(acc >> rem) : 8'd0;
    p.cnt      = rem;
    p.bits     = acc[6:0] & mask;
    return p;
  endfunction

endpackage

[design/ai5p_if.sv]
// ----------------------------------------------------------------------------
// ai5p channel interfaces
// Valid/ready channels for symbol requests and packed results.
// ----------------------------------------------------------------------------
interface ai5p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       stream_end;

  modport source (output valid, output symbol, output stream_end, input ready);
  modport sink   (input valid, input symbol, input stream_end, output ready);
endinterface

interface ai5p_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       byte_present;
  logic       symbol_unknown;
  logic       run_last;
  logic       stream_done;

  modport source (output valid, output packed_byte, output byte_present,
                  output symbol_unknown, output run_last, output stream_done,
                  input ready);
  modport sink   (input valid, input packed_byte, input byte_present,
                  input symbol_unknown, input run_last, input stream_done,
                  output ready);
endinterface

[design/ai5p_match.sv]
// ----------------------------------------------------------------------------
// ai5p_match
// Parallel compare of a symbol against the alphabet; lowest index wins.
// ----------------------------------------------------------------------------
module ai5p_match (
  input  logic [7:0]                  alpha [ai5p_pkg::AlphabetSize],
  input  logic [ai5p_pkg::CodeW-1:0]  count,
  input  logic [7:0]                  symbol,
  output logic                        found,
  output logic [ai5p_pkg::CodeW-1:0]  code
);

  logic [ai5p_pkg::CodeW-1:0]       used;
  logic [ai5p_pkg::AlphabetSize-1:0] hit;

  assign used = (count > ai5p_pkg::CodeW'(ai5p_pkg::AlphabetSize)) ?
                ai5p_pkg::CodeW'(ai5p_pkg::AlphabetSize) : count;

  always_comb begin
    for (int i = 0; i < ai5p_pkg::AlphabetSize; i++) begin
      hit[i] = (alpha[i] == symbol) && (ai5p_pkg::CodeW'(i) < used);
    end
  end

  // Priority pick: scan from the top so the lowest hit is left standing.
  always_comb begin
    code = '0;
    for (int i = ai5p_pkg::AlphabetSize - 1; i >= 0; i--) begin
      if (hit[i]) begin
        code = ai5p_pkg::CodeW'(i);
      end
    end
  end

  assign found = |hit;

endmodule

[design/ai5p_pack.sv]
// ----------------------------------------------------------------------------
// ai5p_pack
// Bit accumulator: appends codes, flushes the terminator and pad, and lists
// the results of one request.
// ----------------------------------------------------------------------------
module ai5p_pack (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic                       found,
  input  logic [ai5p_pkg::CodeW-1:0] code,
  input  logic                       last,
  output ai5p_pkg::pack_out_t        pout
);

  logic [6:0] pending_bits, pending_bits_next;
  logic [2:0] pending_count, pending_count_next;

  ai5p_pkg::push_t p1, p2;
  logic [6:0]      bits1;
  logic [2:0]      cnt1;
  logic [7:0]      pad_byte;
  ai5p_pkg::res_t  cand [4];
  logic [3:0]      cand_ok;
  logic [1:0]      n;

  always_comb begin
    p1    = ai5p_pkg::push_code(pending_bits, pending_count, code);
    bits1 = found ? p1.bits : pending_bits;
    cnt1  = found ? p1.cnt  : pending_count;
    p2    = ai5p_pkg::push_code(bits1, cnt1, ai5p_pkg::TermCode);
    pad_byte = 8'({1'b0, p2.bits} << (4'd8 - {1'b0, p2.cnt}));

    cand[0] = '{packed_byte: 8'd0, byte_present: 1'b0, symbol_unknown: 1'b1,
                run_last: 1'b0, stream_done: 1'b0};
    cand[1] = '{packed_byte: p1.byte_out, byte_present: 1'b1, symbol_unknown: 1'b0,
                run_last: 1'b0, stream_done: 1'b0};
    cand[2] = '{packed_byte: p2.byte_out, byte_present: 1'b1, symbol_unknown: 1'b0,
                run_last: 1'b0, stream_done: 1'b0};
    cand[3] = '{packed_byte: pad_byte, byte_present: 1'b1, symbol_unknown: 1'b0,
                run_last: 1'b0, stream_done: 1'b0};
    cand_ok = {last && (p2.cnt != 3'd0), last && p2.emit, found && p1.emit, !found};

    // Compact the candidates into delivery order.
    pout = '0;
    n    = 2'd0;
    for (int j = 0; j < 4; j++) begin
      if (cand_ok[j]) begin
        pout.res[n] = cand[j];
        n = n + 2'd1;
      end
    end
    pout.num = n;
    if (n != 2'd0) begin
      pout.res[n - 2'd1].run_last    = 1'b1;
      pout.res[n - 2'd1].stream_done = last;
    end
  end

  always_comb begin
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    if (advance) begin
      if (last) begin
        pending_bits_next  = '0;
        pending_count_next = '0;
      end else begin
        pending_bits_next  = bits1;
        pending_count_next = cnt1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

endmodule

[design/alphabet_index_5bit_packer.sv]
// ----------------------------------------------------------------------------
// alphabet_index_5bit_packer
// Codes byte symbols as 5-bit alphabet indexes and packs them MSB-first
// into bytes, with a terminator code and zero pad at stream end.
// ----------------------------------------------------------------------------
// Path: a request waits in the input stage, its results in the result queue.
// Throughput: one request per cycle while each gives at most one result and the
//   output is ready; more results hold the single output port until all leave.
// Reset (rst, synchronous, active high): alphabet bytes clear to zero, the
//   entry count goes to 31, the bit accumulator and both stages empty.
// ----------------------------------------------------------------------------
module alphabet_index_5bit_packer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ai5p_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ai5p_pkg::CfgDataW-1:0] cfg_data,
  ai5p_in_if.sink                       items,
  ai5p_out_if.source                    results
);

  // Alphabet storage: entry e lives in register e/8, byte lane e%8.
  logic [7:0]                 alpha [ai5p_pkg::AlphabetSize];
  logic [ai5p_pkg::CodeW-1:0] count;

  // Input stage.
  logic       in_full;
  logic [7:0] sym;
  logic       sym_end;

  // Result queue: up to three results of one request, drained in order.
  ai5p_pkg::res_t [ai5p_pkg::MaxResults-1:0] q;
  logic [1:0] q_num;
  logic [1:0] q_rd;

  logic                       found;
  logic [ai5p_pkg::CodeW-1:0] code;
  ai5p_pkg::pack_out_t        pout;
  logic                       take;
  logic                       q_free;
  logic                       advance;
  logic                       accept;

  // Configuration writes; indexes beyond the list fall through untouched.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < ai5p_pkg::AlphabetSize; e++) begin
        alpha[e] <= 8'd0;
      end
      count <= ai5p_pkg::CodeW'(ai5p_pkg::AlphabetSize);
    end else if (cfg_we) begin
      for (int e = 0; e < ai5p_pkg::AlphabetSize; e++) begin
        if (cfg_index == ai5p_pkg::CfgIdxW'(e / 8)) begin
          alpha[e] <= cfg_data[(e % 8) * 8 +: 8];
        end
      end
      if (cfg_index == ai5p_pkg::CfgCount) begin
        count <= cfg_data[ai5p_pkg::CodeW-1:0];
      end
    end
  end

  // Handshake: the queue frees up when empty or when its last result leaves.
  assign take    = results.valid && results.ready;
  assign q_free  = (q_num == 2'd0) || ((q_num == 2'd1) && results.ready);
  assign advance = in_full && q_free;
  assign items.ready = !in_full || advance;
  assign accept  = items.valid && items.ready;

  // Hold the request in the input stage until its results can be queued.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sym     <= items.symbol;
      sym_end <= items.stream_end;
    end
  end

  ai5p_match u_match (
    .alpha  (alpha),
    .count  (count),
    .symbol (sym),
    .found  (found),
    .code   (code)
  );

  ai5p_pack u_pack (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .found   (found),
    .code    (code),
    .last    (sym_end),
    .pout    (pout)
  );

  // Load a fresh result set on advance, otherwise advance the read pointer on a take.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_num <= 2'd0;
      q_rd  <= 2'd0;
    end else if (advance) begin
      q_num <= pout.num;
      q_rd  <= 2'd0;
    end else if (take) begin
      q_num <= q_num - 2'd1;
      q_rd  <= q_rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      q <= pout.res;
    end
  end

  assign results.valid          = (q_num != 2'd0);
  assign results.packed_byte    = q[q_rd].packed_byte;
  assign results.byte_present   = q[q_rd].byte_present;
  assign results.symbol_unknown = q[q_rd].symbol_unknown;
  assign results.run_last       = q[q_rd].run_last;
  assign results.stream_done    = q[q_rd].stream_done;

endmodule

[design/ai5p_check.sv]
// ----------------------------------------------------------------------------
// ai5p_check
// Port-level checks on the result channel of the alphabet packer.
// ----------------------------------------------------------------------------
module ai5p_check (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_byte,
  input logic       res_present,
  input logic       res_unknown,
  input logic       res_last,
  input logic       res_done
);

  // An error result carries no byte and never ends the stream.
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_unknown |-> !res_present && (res_byte == 8'd0) && !res_done)
    else $error("error result carries byte data");

  // Every result is either a byte or an error, never neither.
  a_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_present != res_unknown))
    else $error("result is neither byte nor error");

  // The stream's final result is a byte and closes its request too.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_done |-> res_last && res_present)
    else $error("stream end not on a request's last byte");

  // Drop everything on reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_byte) && $stable(res_last))
    else $error("stalled result changed");

endmodule

bind alphabet_index_5bit_packer ai5p_check u_ai5p_check (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (results.valid),
  .res_ready   (results.ready),
  .res_byte    (results.packed_byte),
  .res_present (results.byte_present),
  .res_unknown (results.symbol_unknown),
  .res_last    (results.run_last),
  .res_done    (results.stream_done)
);
